// File: src/tos_pkg.sv
`timescale 1ns / 1ps

package tos_pkg;

    localparam int TOS_COORD_BITS = 16;
    localparam int TOS_VERTS      = 6;
    localparam int TOS_AXES       = 6;

    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
    } tos_en_t;

endpackage

// File: src/tos_axis.sv
`timescale 1ns / 1ps

module tos_axis import tos_pkg::*; #(
    parameter int COORD_BITS = TOS_COORD_BITS
) (
    input  logic                         aclk,
    input  tos_en_t                      en,
    input  logic signed [COORD_BITS:0]   nx,
    input  logic signed [COORD_BITS:0]   ny,
    input  logic signed [COORD_BITS-1:0] vx [TOS_VERTS],
    input  logic signed [COORD_BITS-1:0] vy [TOS_VERTS],
    output logic                         meets
);

    localparam int PW = 2 * COORD_BITS + 1;
    localparam int SW = 2 * COORD_BITS + 2;

    logic signed [PW-1:0] px_reg   [TOS_VERTS];
    logic signed [PW-1:0] py_reg   [TOS_VERTS];
    logic signed [SW-1:0] proj_reg [TOS_VERTS];
    logic signed [SW-1:0] lo_next  [2];
    logic signed [SW-1:0] hi_next  [2];
    logic signed [SW-1:0] lo_reg   [2];
    logic signed [SW-1:0] hi_reg   [2];

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            for (int i = 0; i < TOS_VERTS; i++) begin
                px_reg[i] <= vx[i] * nx;
                py_reg[i] <= vy[i] * ny;
            end
        end
        if (en.en4) begin
            for (int i = 0; i < TOS_VERTS; i++) begin
                proj_reg[i] <= SW'(px_reg[i]) + SW'(py_reg[i]);
            end
        end
        if (en.en5) begin
            for (int t = 0; t < 2; t++) begin
                lo_reg[t] <= lo_next[t];
                hi_reg[t] <= hi_next[t];
            end
        end
    end

    // per-triangle interval on this axis
    always_comb begin
        for (int t = 0; t < 2; t++) begin
            lo_next[t] = proj_reg[t*3];
            hi_next[t] = proj_reg[t*3];
            for (int k = 1; k < 3; k++) begin
                if (proj_reg[t*3+k] < lo_next[t]) lo_next[t] = proj_reg[t*3+k];
                if (proj_reg[t*3+k] > hi_next[t]) hi_next[t] = proj_reg[t*3+k];
            end
        end
    end

    assign meets = (hi_reg[0] >= lo_reg[1]) && (hi_reg[1] >= lo_reg[0]);

endmodule

// File: src/triangle_overlap_sat_2d.sv
`timescale 1ns / 1ps
// Triangle pair overlap test, separating axis method on the edge normals of both triangles.
// Input channel s_*: one word carries both triangles, twelve signed
// coordinates of COORD_BITS each, packed from the lowest bit up as
// a_x0 a_y0 a_x1 a_y1 a_x2 a_y2 b_x0 b_y0 b_x1 b_y1 b_x2 b_y2, padded to bytes.
// Output channel m_*: one word per input word, m_tdata[0] = overlap, upper
// bits zero. Touching triangles overlap; a zero-length edge gives 0.
// Pipeline of six register stages: input capture, edge normals, products,
// projections, per-axis min/max, result register. An accepted word passes
// through these stages in that order before m_tvalid rises for it;
// one word is accepted every cycle while the output drains.
// Each stage loads when it is empty or its successor moves, so bubbles are
// squeezed out and a stall on m_tready holds the output word and backs up
// stage by stage; s_tready falls only once all six stages are full.
// Reset (aresetn low, synchronous) empties every stage; words in flight are
// dropped and m_tvalid is low after the reset edge.
module triangle_overlap_sat_2d import tos_pkg::*; #(
    parameter int COORD_BITS = TOS_COORD_BITS,
    localparam int InW = ((12 * COORD_BITS + 7) / 8) * 8,
    localparam int OutW = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [InW-1:0] s_tdata,   // a_x0 a_y0 a_x1 a_y1 a_x2 a_y2 b_x0 .. b_y2
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [OutW-1:0] m_tdata   // overlap
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    logic [6:1] valid_reg, valid_next, ready;

    logic signed [CB-1:0] vx1_reg [TOS_VERTS];
    logic signed [CB-1:0] vy1_reg [TOS_VERTS];
    logic signed [CB-1:0] vx2_reg [TOS_VERTS];
    logic signed [CB-1:0] vy2_reg [TOS_VERTS];
    logic signed [DW-1:0] nx2_reg [TOS_AXES];
    logic signed [DW-1:0] ny2_reg [TOS_AXES];
    logic signed [DW-1:0] dx      [TOS_AXES];
    logic signed [DW-1:0] dy      [TOS_AXES];
    logic [TOS_AXES-1:0]  zero_edge;
    logic [TOS_AXES-1:0]  meets;
    logic                 z2_reg, z3_reg, z4_reg, z5_reg;
    logic                 overlap_reg;
    tos_en_t              en;

    always_comb begin
        ready[6] = !valid_reg[6] || m_tready;
        for (int k = 5; k >= 1; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next[1] = ready[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= 6; k++) begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    generate
        for (genvar j = 0; j < TOS_AXES; j++) begin : g_edge
            localparam int T = j / 3;
            localparam int E = j % 3;
            localparam int F = (E + 1) % 3;
            assign dx[j] = DW'(vx1_reg[T*3+F]) - DW'(vx1_reg[T*3+E]);
            assign dy[j] = DW'(vy1_reg[T*3+F]) - DW'(vy1_reg[T*3+E]);
            assign zero_edge[j] = (dx[j] == '0) && (dy[j] == '0);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            for (int i = 0; i < TOS_VERTS; i++) begin
                vx1_reg[i] <= s_tdata[(2*i)*CB +: CB];
                vy1_reg[i] <= s_tdata[(2*i+1)*CB +: CB];
            end
        end
        if (ready[2]) begin
            for (int i = 0; i < TOS_VERTS; i++) begin
                vx2_reg[i] <= vx1_reg[i];
                vy2_reg[i] <= vy1_reg[i];
            end
            for (int j = 0; j < TOS_AXES; j++) begin
                nx2_reg[j] <= -dy[j];
                ny2_reg[j] <= dx[j];
            end
            z2_reg <= |zero_edge;
        end
        if (ready[3]) z3_reg <= z2_reg;
        if (ready[4]) z4_reg <= z3_reg;
        if (ready[5]) z5_reg <= z4_reg;
        if (ready[6]) overlap_reg <= (&meets) && !z5_reg;
    end

    assign en.en3 = ready[3];
    assign en.en4 = ready[4];
    assign en.en5 = ready[5];

    generate
        for (genvar j = 0; j < TOS_AXES; j++) begin : g_axis
            tos_axis #(
                .COORD_BITS(COORD_BITS)
            ) u_axis (
                .aclk  (aclk),
                .en    (en),
                .nx    (nx2_reg[j]),
                .ny    (ny2_reg[j]),
                .vx    (vx2_reg),
                .vy    (vy2_reg),
                .meets (meets[j])
            );
        end
    endgenerate

    assign s_tready = ready[1];
    assign m_tvalid = valid_reg[6];
    assign m_tdata  = {{(OutW-1){1'b0}}, overlap_reg};

endmodule

// File: src/tos_check.sv
`timescale 1ns / 1ps

module tos_check (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word survived reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("nonzero padding in output word");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed during stall");

endmodule

bind triangle_overlap_sat_2d tos_check u_tos_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/tb_triangle_overlap_sat_2d.sv
`timescale 1ns / 1ps

module tb_triangle_overlap_sat_2d import tos_pkg::*; ();

    localparam int CB          = TOS_COORD_BITS;
    localparam int IN_W        = ((12 * CB + 7) / 8) * 8;
    localparam int OUT_W       = 8;
    localparam int DIR_N       = 23;
    localparam int PHASE_ITEMS = 560;
    localparam int BURST_ITEMS = 40;
    localparam int HOLD_LEN    = 80;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TX_IDLE [3] = '{19, 87, 0};
    localparam int RX_IDLE [3] = '{87, 19, 0};

    typedef logic [IN_W-1:0]        pair_t;
    typedef logic signed [CB-1:0]   coord_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_NO, EXP_YES} dir_exp_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    pair_t            s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    bit overlap_q [$];
    bit exp_ovl;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int rx_hold      = 0;
    int err_cnt      = 0;
    int sent_cnt     = 0;
    int got_cnt      = 0;
    int ones_cnt     = 0;
    int cyc          = 0;

    // a_x0 a_y0 a_x1 a_y1 a_x2 a_y2 b_x0 b_y0 b_x1 b_y1 b_x2 b_y2
    int dir_pts [DIR_N][12] = '{
        '{0, 0, 10, 0, 0, 10,  0, 0, 10, 0, 0, 10},
        '{0, 0, 10, 0, 0, 10,  100, 100, 110, 100, 100, 110},
        '{0, 0, 10, 0, 0, 10,  10, 0, 20, 0, 10, 10},
        '{0, 0, 10, 0, 0, 10,  10, 0, 0, 10, 10, 10},
        '{0, 0, 10, 0, 0, 10,  10, 1, 1, 10, 10, 10},
        '{0, 0, 0, 0, 0, 10,  -5, -5, 20, -5, -5, 20},
        '{0, 0, 10, 0, 0, 0,  -5, -5, 20, -5, -5, 20},
        '{0, 0, 10, 0, 0, 10,  1, 1, 5, 5, 5, 5},
        '{3, 3, 3, 3, 3, 3,  3, 3, 3, 3, 3, 3},
        '{0, 0, 5, 5, 10, 10,  0, 10, 10, 0, 10, 10},
        '{0, 0, 1, 1, 2, 2,  5, 5, 6, 6, 7, 7},
        '{-32768, -32768, 32767, -32768, -32768, 32767,
          -32768, -32768, 32767, -32768, -32768, 32767},
        '{-32768, -32768, 32767, -32768, -32768, 32767,  -1, -1, 1, -1, 0, 1},
        '{32767, 32767, 32767, 32766, 32766, 32767,
          -32768, -32768, -32767, -32768, -32768, -32767},
        '{-32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768, -32768, -32768, -32768, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767,
          32767, 32767, 32767, 32767, 32767, 32767},
        '{-100, -100, 100, -100, 0, 100,  -1, -1, 1, -1, 0, 1},
        '{-1, -1, 1, -1, 0, 1,  -100, -100, 100, -100, 0, 100},
        '{0, 0, 0, 10, 10, 0,  2, 2, 12, 2, 2, 12},
        '{-1, -1, 0, -1, -1, 0,  0, 0, -1, 0, 0, -1},
        '{0, 0, 20, 0, 10, 18,  0, 12, 20, 12, 10, -6},
        '{0, 0, 10, 0, 0, 10,  6, 6, 20, 6, 6, 20},
        '{-32768, 32767, 32767, -32768, 0, 0,  32767, 32767, -32768, -32768, -1, 1}
    };
    dir_exp_t dir_exp [DIR_N] = '{
        EXP_YES, EXP_NO, EXP_YES, EXP_YES, EXP_NO, EXP_NO, EXP_NO, EXP_NO, EXP_NO,
        EXP_PRED, EXP_PRED, EXP_YES, EXP_PRED, EXP_NO, EXP_NO, EXP_NO, EXP_YES,
        EXP_YES, EXP_PRED, EXP_YES, EXP_PRED, EXP_PRED, EXP_PRED
    };

    triangle_overlap_sat_2d u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, overlap_q.size());
            $display("triangle_overlap_sat_2d verification failed");
            $finish;
        end
    end

    // separating axis test on the edge normals of both triangles, exact integer math
    function automatic bit sat_overlap(input pair_t w);
        longint vx [6];
        longint vy [6];
        longint dx, dy, p, lo_a, hi_a, lo_b, hi_b;
        coord_t c;
        bit ok;
        int t, e, f, k;
        for (k = 0; k < 6; k++) begin
            c = w[(2 * k) * CB +: CB];
            vx[k] = c;
            c = w[(2 * k + 1) * CB +: CB];
            vy[k] = c;
        end
        ok = 1'b1;
        for (t = 0; t < 2; t++) begin
            for (e = 0; e < 3; e++) begin
                f  = (e + 1) % 3;
                dx = vx[3 * t + f] - vx[3 * t + e];
                dy = vy[3 * t + f] - vy[3 * t + e];
                if (dx == 0 && dy == 0) begin
                    ok = 1'b0;
                end else begin
                    for (k = 0; k < 6; k++) begin
                        p = -dy * vx[k] + dx * vy[k];
                        if (k < 3) begin
                            if (k == 0 || p < lo_a) lo_a = p;
                            if (k == 0 || p > hi_a) hi_a = p;
                        end else begin
                            if (k == 3 || p < lo_b) lo_b = p;
                            if (k == 3 || p > hi_b) hi_b = p;
                        end
                    end
                    if (!(hi_a >= lo_b && hi_b >= lo_a)) ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic pair_t rand_pair();
        int v [12];
        int ext [7] = '{-32768, 32767, 0, -1, 1, -32767, 32766};
        int mode, r, cx, cy, dx, dy, m, t, e, f, s, i;
        pair_t w;
        mode = $urandom_range(99);
        r  = 1 << $urandom_range(9);
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        for (i = 0; i < 12; i++)
            v[i] = ((i % 2) ? cy : cx) + int'($urandom_range(2 * r)) - r;
        if (mode < 30) begin
            for (i = 0; i < 12; i++) v[i] = $urandom();
        end else if (mode < 65) begin
            // clustered pairs, mixed outcome
        end else if (mode < 75) begin
            // touching: shared vertex, sometimes a shared edge
            s = $urandom_range(2);
            v[6] = v[2 * s];
            v[7] = v[2 * s + 1];
            if ($urandom_range(1)) begin
                f = (s + 1) % 3;
                v[8] = v[2 * f];
                v[9] = v[2 * f + 1];
            end
        end else if (mode < 83) begin
            t = $urandom_range(1);
            e = $urandom_range(2);
            f = (e + 1) % 3;
            v[6 * t + 2 * f]     = v[6 * t + 2 * e];
            v[6 * t + 2 * f + 1] = v[6 * t + 2 * e + 1];
        end else if (mode < 91) begin
            t  = $urandom_range(1);
            dx = int'($urandom_range(2 * r)) - r;
            dy = int'($urandom_range(2 * r)) - r;
            for (i = 0; i < 3; i++) begin
                m = int'($urandom_range(4)) - 2;
                v[6 * t + 2 * i]     = cx + m * dx;
                v[6 * t + 2 * i + 1] = cy + m * dy;
            end
        end else begin
            for (i = 0; i < 12; i++) v[i] = ext[$urandom_range(6)];
        end
        w = '0;
        for (i = 0; i < 12; i++) w[i * CB +: CB] = v[i][CB-1:0];
        return w;
    endfunction

    task automatic send_pair(input pair_t w, input bit ovl);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        overlap_q.push_back(ovl);
        sent_cnt++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (overlap_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (overlap_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                err_cnt++;
            end else begin
                exp_ovl = overlap_q.pop_front();
                got_cnt++;
                ones_cnt += exp_ovl;
                if (m_tdata !== {{(OUT_W-1){1'b0}}, exp_ovl}) begin
                    $display("%0t: overlap mismatch, expected %h, actual %h",
                             $time, {{(OUT_W-1){1'b0}}, exp_ovl}, m_tdata);
                    err_cnt++;
                end
            end
        end
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            rx_hold      = HOLD_LEN;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        pair_t w;
        int ph, i, k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = TX_IDLE[ph];
            rx_idle_pct <= RX_IDLE[ph];
            if (ph == 0) begin
                for (i = 0; i < DIR_N; i++) begin
                    w = '0;
                    for (k = 0; k < 12; k++) w[k * CB +: CB] = dir_pts[i][k][CB-1:0];
                    case (dir_exp[i])
                        EXP_YES: send_pair(w, 1'b1);
                        EXP_NO:  send_pair(w, 1'b0);
                        default: send_pair(w, sat_overlap(w));
                    endcase
                end
            end
            if (ph == 2) begin
                // stall the output long enough to fill the pipe and block s_tready
                hold_req_cnt <= hold_req_cnt + 1;
                for (i = 0; i < BURST_ITEMS; i++) begin
                    w = rand_pair();
                    send_pair(w, sat_overlap(w));
                end
                drain_results();
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                w = rand_pair();
                send_pair(w, sat_overlap(w));
            end
            drain_results();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (overlap_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, overlap_q.size());
            err_cnt++;
        end
        $display("%0d triangle pairs sent (%0d directed), %0d results checked, %0d overlapping",
                 sent_cnt, DIR_N, got_cnt, ones_cnt);
        $display("covered extremes, touching, zero-length and collinear edges, stall fill/drain");
        if (err_cnt == 0) begin
            $display("triangle_overlap_sat_2d verification clean");
        end else begin
            $display("triangle_overlap_sat_2d verification failed");
        end
        $finish;
    end

endmodule
